[sv/brst_pkg.sv]
// Shared constants and types of the bucketed range-sum table.
package brst_pkg;

   localparam int DEF_CAPACITY    = 1024;
   localparam int DEF_BUCKET_SIZE = 32;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int MODE_W  = 2;
   localparam int POS_W   = 10;
   localparam int INDEX_W = 11;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_SET   = 2'd0,
      MODE_GET   = 2'd1,
      MODE_RANGE = 2'd2,
      MODE_TOTAL = 2'd3
   } mode_type;

endpackage

[sv/brst_if.sv]
// Channel interfaces of the bucketed range-sum table: request, response and register write.
interface brst_req_if;
   import brst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [POS_W-1:0]      position;
   logic [INDEX_W-1:0]    range_start;
   logic [INDEX_W-1:0]    range_end;
   logic [DATA_W-1:0]     new_value;

   modport source (output valid, mode, position, range_start, range_end, new_value,
                   input ready);
   modport sink   (input valid, mode, position, range_start, range_end, new_value,
                   output ready);
endinterface

interface brst_rsp_if;
   import brst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [DATA_W-1:0]     result_value;
   logic                  status;

   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

interface brst_csr_if;
   import brst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COUNT_W-1:0]    element_count;

   modport source (output valid, element_count, input ready);
   modport sink   (input valid, element_count, output ready);
endinterface

[sv/brst_ram.sv]
// Single-port-write, single-port-read RAM with registered read data.
module brst_ram #(
   parameter int  DEPTH = 32,
   parameter int  WIDTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/brst_ctrl.sv]
// Sequencer and shared adder of the bucketed range-sum table.
module brst_ctrl #(
   parameter int  CAPACITY    = brst_pkg::DEF_CAPACITY,
   parameter int  BUCKET_SIZE = brst_pkg::DEF_BUCKET_SIZE,
   parameter int  VALUE_WIDTH = brst_pkg::DEF_VALUE_WIDTH,
   localparam int NUM_BUCKETS = (CAPACITY + BUCKET_SIZE - 1) / BUCKET_SIZE,
   localparam int AW = $clog2(CAPACITY),
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   brst_req_if.sink                         req,
   brst_rsp_if.source                       rsp,
   input  logic [brst_pkg::COUNT_W-1:0]     count,
   output logic                             elem_we,
   output logic [AW-1:0]                    elem_waddr,
   output logic [VALUE_WIDTH-1:0]           elem_wdata,
   output logic                             elem_re,
   output logic [AW-1:0]                    elem_raddr,
   input  logic [VALUE_WIDTH-1:0]           elem_rdata,
   output logic                             bkt_we,
   output logic [BW-1:0]                    bkt_waddr,
   output logic [VALUE_WIDTH-1:0]           bkt_wdata,
   output logic                             bkt_re,
   output logic [BW-1:0]                    bkt_raddr,
   input  logic [VALUE_WIDTH-1:0]           bkt_rdata
);
   import brst_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int XW = COUNT_W;
   localparam int OW = $clog2(BUCKET_SIZE);
   // Index / BUCKET_SIZE as a reciprocal multiply, exact for every XW-bit index.
   localparam int     SH     = XW + OW;
   localparam int     MW     = XW + 2;
   localparam int     PW     = XW + MW;
   localparam longint MULT_L = ((longint'(1) << SH) + BUCKET_SIZE - 1) / BUCKET_SIZE;
   localparam logic [MW-1:0] MULT   = MW'(MULT_L);
   localparam logic [XW-1:0] BS_X   = XW'(BUCKET_SIZE);
   localparam logic [OW-1:0] OFF_LAST = OW'(BUCKET_SIZE - 1);
   localparam logic [AW-1:0] CLR_LAST = AW'(CAPACITY - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_GET_RD, ST_GET_DATA, ST_DIV_MUL, ST_DIV_QUO, ST_DIV_REM,
      ST_SET_RD, ST_SET_DIFF, ST_SET_BKT, ST_SET_TOT, ST_WALK, ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [XW-1:0]    hi_ff, hi_in;
   logic [VW-1:0]    nv_ff, nv_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [XW-1:0]    bkt_ff, bkt_in;
   logic [OW-1:0]    off_ff, off_in;
   logic [XW-1:0]    cur_ff, cur_in;
   logic [VW-1:0]    acc_ff, acc_in;
   logic [VW-1:0]    total_ff, total_in;
   logic             pend_ff, pend_in;
   logic             pend_bkt_ff, pend_bkt_in;
   logic [VW-1:0]    res_ff, res_in;
   logic             stat_ff, stat_in;
   logic [VW-1:0]    out_res_ff, out_res_in;
   logic             out_stat_ff, out_stat_in;
   logic             rvalid_ff, rvalid_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic [VW-1:0]    add_a, add_b, add_y;
   logic             add_sub;

   // The one adder that the set and range-sum operations share.
   assign add_y = add_a + (add_sub ? ~add_b : add_b) + VW'(add_sub);

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rvalid_ff;
   assign rsp.result_value = DATA_W'(out_res_ff);
   assign rsp.status       = out_stat_ff;

   always_comb begin
      logic           acc_err;
      logic           whole;
      mode_type       req_mode;
      state_in    = state_ff;
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      hi_in       = hi_ff;
      nv_in       = nv_ff;
      x_in        = x_ff;
      prod_in     = prod_ff;
      bkt_in      = bkt_ff;
      off_in      = off_ff;
      cur_in      = cur_ff;
      acc_in      = acc_ff;
      total_in    = total_ff;
      pend_in     = pend_ff;
      pend_bkt_in = pend_bkt_ff;
      res_in      = res_ff;
      stat_in     = stat_ff;
      out_res_in  = out_res_ff;
      out_stat_in = out_stat_ff;
      rvalid_in   = rvalid_ff;
      clr_in      = clr_ff;
      elem_we     = 1'b0;
      elem_waddr  = AW'(pos_ff);
      elem_wdata  = nv_ff;
      elem_re     = 1'b0;
      elem_raddr  = AW'(pos_ff);
      bkt_we      = 1'b0;
      bkt_waddr   = BW'(bkt_ff);
      bkt_wdata   = add_y;
      bkt_re      = 1'b0;
      bkt_raddr   = BW'(bkt_ff);
      add_a       = acc_ff;
      add_b       = pend_bkt_ff ? bkt_rdata : elem_rdata;
      add_sub     = 1'b0;
      acc_err     = 1'b0;
      whole       = 1'b0;
      req_mode    = mode_type'(req.mode);

      if (rsp.valid && rsp.ready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            elem_we    = 1'b1;
            elem_waddr = clr_ff;
            elem_wdata = '0;
            bkt_we     = (32'(clr_ff) < NUM_BUCKETS);
            bkt_waddr  = BW'(clr_ff);
            bkt_wdata  = '0;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               mode_in = req_mode;
               pos_in  = req.position;
               nv_in   = VW'(req.new_value);
               hi_in   = req.range_end;
               acc_in  = '0;
               stat_in = STATUS_OK;
               res_in  = '0;
               case (req_mode)
                  MODE_SET, MODE_GET: begin
                     acc_err = (XW'(req.position) >= count) ||
                               (32'(req.position) >= CAPACITY);
                     x_in    = XW'(req.position);
                     if (acc_err) begin
                        stat_in  = STATUS_ERR;
                        state_in = ST_FINISH;
                     end else if (req_mode == MODE_GET) begin
                        state_in = ST_GET_RD;
                     end else begin
                        state_in = ST_DIV_MUL;
                     end
                  end
                  MODE_RANGE: begin
                     acc_err = (req.range_start > req.range_end) ||
                               (req.range_end > count);
                     x_in    = req.range_start;
                     if (acc_err) begin
                        stat_in  = STATUS_ERR;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_DIV_MUL;
                     end
                  end
                  default: begin
                     res_in   = total_ff;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_GET_RD: begin
            elem_re  = 1'b1;
            state_in = ST_GET_DATA;
         end
         ST_GET_DATA: begin
            res_in   = elem_rdata;
            state_in = ST_FINISH;
         end
         ST_DIV_MUL: begin
            prod_in  = PW'(x_ff) * PW'(MULT);
            state_in = ST_DIV_QUO;
         end
         ST_DIV_QUO: begin
            bkt_in   = XW'(prod_ff >> SH);
            state_in = ST_DIV_REM;
         end
         ST_DIV_REM: begin
            off_in   = OW'(x_ff - XW'(bkt_ff * BS_X));
            cur_in   = x_ff;
            pend_in  = 1'b0;
            state_in = (mode_ff == MODE_SET) ? ST_SET_RD : ST_WALK;
         end
         ST_SET_RD: begin
            elem_re  = 1'b1;
            bkt_re   = 1'b1;
            state_in = ST_SET_DIFF;
         end
         ST_SET_DIFF: begin
            add_a    = nv_ff;
            add_b    = elem_rdata;
            add_sub  = 1'b1;
            acc_in   = add_y;
            state_in = ST_SET_BKT;
         end
         ST_SET_BKT: begin
            add_a    = bkt_rdata;
            add_b    = acc_ff;
            bkt_we   = 1'b1;
            elem_we  = 1'b1;
            state_in = ST_SET_TOT;
         end
         ST_SET_TOT: begin
            add_a    = total_ff;
            add_b    = acc_ff;
            total_in = add_y;
            state_in = ST_FINISH;
         end
         ST_WALK: begin
            // Data read in the previous cycle is folded in while the next read goes out.
            if (pend_ff) begin
               acc_in = add_y;
            end
            pend_in = 1'b0;
            if (cur_ff < hi_ff) begin
               pend_in = 1'b1;
               whole   = (off_ff == '0) &&
                         (({1'b0, cur_ff} + {1'b0, BS_X}) <= {1'b0, hi_ff});
               if (whole) begin
                  bkt_re      = 1'b1;
                  pend_bkt_in = 1'b1;
                  cur_in      = cur_ff + BS_X;
                  bkt_in      = bkt_ff + XW'(1);
               end else begin
                  elem_re     = 1'b1;
                  elem_raddr  = AW'(cur_ff);
                  pend_bkt_in = 1'b0;
                  cur_in      = cur_ff + XW'(1);
                  if (off_ff == OFF_LAST) begin
                     off_in = '0;
                     bkt_in = bkt_ff + XW'(1);
                  end else begin
                     off_in = off_ff + OW'(1);
                  end
               end
            end else if (!pend_ff) begin
               res_in   = acc_ff;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rvalid_ff || rsp.ready) begin
               out_res_in  = res_ff;
               out_stat_in = stat_ff;
               rvalid_in   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         total_ff  <= '0;
         pend_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         total_ff  <= total_in;
         pend_ff   <= pend_in;
         rvalid_ff <= rvalid_in;
      end
      mode_ff     <= mode_in;
      pos_ff      <= pos_in;
      hi_ff       <= hi_in;
      nv_ff       <= nv_in;
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      bkt_ff      <= bkt_in;
      off_ff      <= off_in;
      cur_ff      <= cur_in;
      acc_ff      <= acc_in;
      pend_bkt_ff <= pend_bkt_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      out_res_ff  <= out_res_in;
      out_stat_ff <= out_stat_in;
   end

endmodule

[sv/bucketed_range_sum_table.sv]
// Top level of the bucketed range-sum table.
// The table holds CAPACITY elements in buckets of BUCKET_SIZE, plus one running sum per
// bucket and a grand total, all wrapping modulo 2^VALUE_WIDTH. Each request transfer
// carries one operation: set an element, get an element, sum a half-open index range,
// or read the grand total; each produces exactly one response transfer. An index or
// range outside the element count in use returns status 1 with a zero value and leaves
// the table untouched. After reset the block sweeps both memories to zero, one entry
// per cycle, before it first raises req_ch.ready; register writes are taken during
// the sweep. The block works on one request at a time and holds ready low until its
// result sits in the output register; a finished response may wait there while the
// next request is already being taken. A range sum walks its memory reads, which are
// the single elements of the partial buckets at either edge plus one bucket sum for
// each whole bucket in between: at most 2*(BUCKET_SIZE-1) + CAPACITY / BUCKET_SIZE
// reads. The element memory and the bucket-sum memory each give one registered read
// per cycle and a single shared adder folds one read in per cycle.
// The element count register is written through the csr_ch channel, which is always
// ready; a value above CAPACITY is clamped to it, and a write clears nothing.
module bucketed_range_sum_table #(
   parameter int CAPACITY    = brst_pkg::DEF_CAPACITY,
   parameter int BUCKET_SIZE = brst_pkg::DEF_BUCKET_SIZE,
   parameter int VALUE_WIDTH = brst_pkg::DEF_VALUE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   brst_req_if.sink    req_ch,
   brst_rsp_if.source  rsp_ch,
   brst_csr_if.sink    csr_ch
);
   import brst_pkg::*;

   localparam int NUM_BUCKETS = (CAPACITY + BUCKET_SIZE - 1) / BUCKET_SIZE;
   localparam int AW = $clog2(CAPACITY);
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam logic [COUNT_W-1:0] COUNT_RESET =
      COUNT_W'((CAPACITY < 1024) ? CAPACITY : 1024);

   logic [COUNT_W-1:0]     count_ff, count_in;

   logic                   elem_we, elem_re;
   logic [AW-1:0]          elem_waddr, elem_raddr;
   logic [VALUE_WIDTH-1:0] elem_wdata, elem_rdata;
   logic                   bkt_we, bkt_re;
   logic [BW-1:0]          bkt_waddr, bkt_raddr;
   logic [VALUE_WIDTH-1:0] bkt_wdata, bkt_rdata;

   // The count register accepts a write in every cycle.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      if (csr_ch.valid) begin
         if (32'(csr_ch.element_count) > CAPACITY) begin
            count_in = COUNT_W'(CAPACITY);
         end else begin
            count_in = csr_ch.element_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // Element values, one entry per index.
   brst_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_en   (elem_re),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   // Running sum of each bucket.
   brst_ram #(
      .DEPTH (NUM_BUCKETS),
      .WIDTH (VALUE_WIDTH)
   ) u_bkt_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_en   (bkt_re),
      .rd_addr (bkt_raddr),
      .rd_data (bkt_rdata)
   );

   brst_ctrl #(
      .CAPACITY    (CAPACITY),
      .BUCKET_SIZE (BUCKET_SIZE),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .count      (count_ff),
      .elem_we    (elem_we),
      .elem_waddr (elem_waddr),
      .elem_wdata (elem_wdata),
      .elem_re    (elem_re),
      .elem_raddr (elem_raddr),
      .elem_rdata (elem_rdata),
      .bkt_we     (bkt_we),
      .bkt_waddr  (bkt_waddr),
      .bkt_wdata  (bkt_wdata),
      .bkt_re     (bkt_re),
      .bkt_raddr  (bkt_raddr),
      .bkt_rdata  (bkt_rdata)
   );

endmodule

[sv/brst_checker.sv]
// Port-level assertions of the bucketed range-sum table and their binding.
module brst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [brst_pkg::DATA_W-1:0]   result_value,
   input logic                          status
);
   import brst_pkg::*;

   // The clearing sweep keeps requests out right after reset.
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready right after reset");

   // One request at a time: a request transfer drops ready.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) && $stable(status))
      else $error("stalled response changed");

   // An error response never carries a value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == STATUS_ERR) |-> result_value == '0)
      else $error("error response with nonzero value");

endmodule

bind bucketed_range_sum_table brst_checker u_brst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .result_value (rsp_ch.result_value),
   .status       (rsp_ch.status)
);

[verif/brst_table_tracker_pkg.sv]
// Scoreboard class that tracks the table contents and checks each response of the block.
`timescale 1ns / 100ps
package brst_table_tracker_pkg;
   import brst_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              status;
   } table_reply_type;

   class sum_table_tracker;
      logic [DATA_W-1:0] element_store [DEF_CAPACITY];
      int unsigned       active_count;
      int unsigned       failures;
      table_reply_type   replies_due [$];

      function new();
         foreach (element_store[i]) element_store[i] = '0;
         active_count = DEF_CAPACITY;
         failures     = 0;
      endfunction

      // Counts above the capacity behave as the capacity; nothing is cleared.
      function void set_count(logic [COUNT_W-1:0] written);
         active_count = (written > DEF_CAPACITY) ? DEF_CAPACITY : written;
      endfunction

      // Range sums and the total are added up from the elements themselves, so the
      // block's bucket bookkeeping is checked against plain element sums.
      function void note_request(mode_type mode, logic [POS_W-1:0] position,
                                 logic [INDEX_W-1:0] range_start,
                                 logic [INDEX_W-1:0] range_end,
                                 logic [DATA_W-1:0] new_value);
         table_reply_type   reply;
         logic [DATA_W-1:0] acc;
         int unsigned       idx;
         reply.value  = '0;
         reply.status = STATUS_OK;
         acc          = '0;
         case (mode)
            MODE_SET, MODE_GET: begin
               if (position >= active_count) begin
                  reply.status = STATUS_ERR;
               end else if (mode == MODE_GET) begin
                  reply.value = element_store[position];
               end else begin
                  element_store[position] = new_value;
               end
            end
            MODE_RANGE: begin
               if (range_start > range_end || range_end > active_count) begin
                  reply.status = STATUS_ERR;
               end else begin
                  for (idx = range_start; idx < range_end; idx++) acc += element_store[idx];
                  reply.value = acc;
               end
            end
            default: begin
               foreach (element_store[i]) acc += element_store[i];
               reply.value = acc;
            end
         endcase
         replies_due.push_back(reply);
      endfunction

      function void check_response(logic [DATA_W-1:0] value, logic status);
         table_reply_type due;
         if (replies_due.size() == 0) begin
            $error("unexpected response: result_value %h status %0b", value, status);
            failures++;
         end else begin
            due = replies_due.pop_front();
            if (value !== due.value) begin
               $error("result_value: expected %h, actual %h", due.value, value);
               failures++;
            end
            if (status !== due.status) begin
               $error("status: expected %0b, actual %0b", due.status, status);
               failures++;
            end
         end
      endfunction

      function int unsigned pending();
         return replies_due.size();
      endfunction
   endclass

endpackage

[verif/bucketed_range_sum_table_test.sv]
// Testbench top that drives requests and register writes into the range-sum table.
`timescale 1ns / 100ps
module bucketed_range_sum_table_test;
   import brst_pkg::*;
   import brst_table_tracker_pkg::*;

   // The watchdog counts cycles without any transfer. The limit sits well above the
   // reset sweep and the longest range sum, so this leaves a wide margin even with the
   // response side stalling half of the time.
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned PHASES      = 8;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned sender_idle_pct   = 28;
   int unsigned receiver_idle_pct = 51;
   int unsigned quiet_cycles      = 0;

   sum_table_tracker tracker;

   brst_req_if req_bus ();
   brst_rsp_if rsp_bus ();
   brst_csr_if csr_bus ();

   bucketed_range_sum_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #2 clock = ~clock;

   // Any transfer on any channel counts as progress. Values are read right after
   // the edge, so they are the ones the edge itself saw.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("bucketed_range_sum_table: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request transfer. Idle gaps come before the item, so valid drops at most
   // once per time step and stays high from one item to the next when no gap falls.
   // The prediction is made at the edge where the transfer happens.
   task automatic send_request(mode_type mode, logic [POS_W-1:0] position,
                               logic [INDEX_W-1:0] range_start,
                               logic [INDEX_W-1:0] range_end,
                               logic [DATA_W-1:0] new_value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= mode;
      req_bus.position    <= position;
      req_bus.range_start <= range_start;
      req_bus.range_end   <= range_end;
      req_bus.new_value   <= new_value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_request(mode, position, range_start, range_end, new_value);
   endtask

   // A register transfer. It is only issued while no request is in flight.
   task automatic write_count(logic [COUNT_W-1:0] value);
      csr_bus.valid         <= 1'b1;
      csr_bus.element_count <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      tracker.set_count(value);
      csr_bus.valid <= 1'b0;
   endtask

   // The last item's valid is dropped first so the block does not take it twice.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Random items are mostly well formed: positions and ranges inside the count in
   // use, with range starts often snapped to a bucket boundary so that whole-bucket
   // sums get used. The rest spans the full field widths to hit the error paths.
   task automatic send_random_item();
      mode_type           mode;
      logic [POS_W-1:0]   position;
      logic [INDEX_W-1:0] range_start;
      logic [INDEX_W-1:0] range_end;
      logic [DATA_W-1:0]  new_value;
      int unsigned        roll;
      int unsigned        in_use;
      in_use = tracker.active_count;
      roll = $urandom_range(0, 99);
      if (roll < 40)      mode = MODE_SET;
      else if (roll < 60) mode = MODE_GET;
      else if (roll < 90) mode = MODE_RANGE;
      else                mode = MODE_TOTAL;
      if (in_use > 0 && $urandom_range(0, 99) < 85) begin
         position = POS_W'($urandom_range(0, in_use - 1));
      end else begin
         position = POS_W'($urandom_range(0, 1023));
      end
      if ($urandom_range(0, 99) < 80) begin
         range_start = INDEX_W'($urandom_range(0, in_use));
         range_end   = INDEX_W'($urandom_range(range_start, in_use));
         if ($urandom_range(0, 99) < 30) range_start = range_start & ~11'd31;
      end else begin
         range_start = INDEX_W'($urandom_range(0, 2047));
         range_end   = INDEX_W'($urandom_range(0, 2047));
      end
      roll = $urandom_range(0, 99);
      if (roll < 10)      new_value = '0;
      else if (roll < 20) new_value = '1;
      else                new_value = $urandom;
      send_request(mode, position, range_start, range_end, new_value);
   endtask

   initial begin
      int unsigned phase_counts [PHASES];
      int unsigned phase_items  [PHASES];
      phase_counts = '{1024, 1, 0, 2047, 33, 700, 1023, 64};
      phase_items  = '{300, 60, 40, 300, 150, 300, 300, 200};
      tracker = new();
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.mode          <= MODE_SET;
      req_bus.position      <= '0;
      req_bus.range_start   <= '0;
      req_bus.range_end     <= '0;
      req_bus.new_value     <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.element_count <= '0;
      rsp_bus.ready         <= 1'b0;

      // The response side stalls at random, once per cycle, for the whole run.
      fork
         forever begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            @(posedge clock);
            if (rsp_bus.valid && rsp_bus.ready) begin
               tracker.check_response(rsp_bus.result_value, rsp_bus.status);
            end
         end
      join_none

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // An oversized count must act as the full capacity. The write lands during the
      // clearing sweep, which the block allows.
      write_count(11'd2047);

      // Directed items: the value extremes, the table ends, bucket edges, the empty
      // range and every way a range can be out of bounds.
      send_request(MODE_TOTAL, 10'd0, 11'd0, 11'd0, 32'd0);
      send_request(MODE_GET, 10'd0, 11'd0, 11'd0, 32'd0);
      send_request(MODE_SET, 10'd0, 11'd0, 11'd0, 32'hFFFF_FFFF);
      send_request(MODE_SET, 10'd1023, 11'd0, 11'd0, 32'd1);
      send_request(MODE_SET, 10'd31, 11'd0, 11'd0, 32'h8000_0000);
      send_request(MODE_SET, 10'd32, 11'd0, 11'd0, 32'd5);
      send_request(MODE_GET, 10'd1023, 11'd0, 11'd0, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd0, 11'd1024, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd0, 11'd0, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd1024, 11'd1024, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd1, 11'd1023, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd31, 11'd33, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd0, 11'd32, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd2047, 11'd2047, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd10, 11'd5, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd0, 11'd1025, 32'd0);
      send_request(MODE_SET, 10'd0, 11'd0, 11'd0, 32'h1234_5678);
      send_request(MODE_TOTAL, 10'd0, 11'd0, 11'd0, 32'd0);
      wait_drained();

      // With no elements in use every set and get fails, yet the total still covers
      // all stored elements.
      write_count(11'd0);
      send_request(MODE_SET, 10'd0, 11'd0, 11'd0, 32'hDEAD_BEEF);
      send_request(MODE_GET, 10'd0, 11'd0, 11'd0, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd0, 11'd0, 32'd0);
      send_request(MODE_TOTAL, 10'd0, 11'd0, 11'd0, 32'd0);
      wait_drained();

      write_count(11'd1000);
      send_request(MODE_GET, 10'd1010, 11'd0, 11'd0, 32'd0);
      send_request(MODE_RANGE, 10'd0, 11'd0, 11'd1000, 32'd0);
      send_request(MODE_TOTAL, 10'd0, 11'd0, 11'd0, 32'd0);

      // Random phases, each under its own element count. The first three let the
      // sender idle lightly and the receiver heavily, the next three the reverse,
      // and the last two run with no idling at all.
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         if (phase < 3) begin
            sender_idle_pct   = 28;
            receiver_idle_pct = 51;
         end else if (phase < 6) begin
            sender_idle_pct   = 51;
            receiver_idle_pct = 28;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         write_count(COUNT_W'(phase_counts[phase]));
         repeat (phase_items[phase]) send_random_item();
      end
      req_bus.valid <= 1'b0;

      // Let every response drain, then give the block time to show any extra one.
      wait_drained();
      repeat (16) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("bucketed_range_sum_table: match");
      end else begin
         $display("bucketed_range_sum_table: mismatch");
      end
      $finish;
   end

endmodule
